// File: hdl/imm_pkg.sv
// Shared types and constants of the integer matrix multiply block.
package imm_pkg;

	localparam int DIM_DEFAULT = 8;

	localparam int DATA_W = 32;
	localparam int DIMREG_W = 4;
	localparam int IDX_W = 3;
	localparam int ADDR_W_APB = 4;

	localparam logic [1:0] MODE_WR_A = 2'd0;
	localparam logic [1:0] MODE_WR_B = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [1:0] REG_ROWS_A = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B = 2'd2;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [DATA_W-1:0] element;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product;
		logic                     index_error;
	} result_t;

endpackage

// File: hdl/integer_matrix_multiply.sv
// Top level of the integer matrix multiply block.
// Writes of A or B elements are taken on any cycle in which busy is low and
// give no result unless an index is out of range. A read request holds busy
// until its result is out: one multiply-accumulate per cycle, paced by the
// single read port of each store and one 32x32 multiplier, followed by the
// memory read and multiply stages. Out-of-range requests and reads with
// inner_dim of zero answer in the cycle after they are taken. Every result
// shows for exactly one cycle with done high; the receiver cannot stall it.
module integer_matrix_multiply #(
	parameter int DIM = imm_pkg::DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  imm_pkg::cmd_t                  cmd,
	output logic                           done,
	output imm_pkg::result_t               result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [imm_pkg::ADDR_W_APB-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int DEPTH = DIM * DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [imm_pkg::DIMREG_W-1:0] DimCap =
		imm_pkg::DIMREG_W'((DIM > 15) ? 15 : DIM);
	localparam logic [imm_pkg::DIMREG_W-1:0] DimReset =
		imm_pkg::DIMREG_W'((DIM < 8) ? DIM : 8);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t state_q;

	logic [imm_pkg::DIMREG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [imm_pkg::DIMREG_W-1:0] cfg_val;
	logic                         cfg_we;

	logic [imm_pkg::IDX_W-1:0]    row_q, col_q;
	logic [imm_pkg::DIMREG_W-1:0] k_q;
	logic                         v_s1, last_s1, v_s2, last_s2;
	logic [imm_pkg::DATA_W-1:0]   prod_s2, acc_q;
	logic [imm_pkg::DATA_W-1:0]   mul_full;

	logic                         accept;
	logic                         a_ok, b_ok, r_ok;
	logic                         a_we, b_we;
	logic [AW-1:0]                w_addr, a_raddr, b_raddr;
	logic [imm_pkg::DATA_W-1:0]   a_rdata, b_rdata;
	logic [imm_pkg::DIMREG_W-1:0] row_x, col_x;
	logic                         last_issue;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign cfg_val = (pwdata[imm_pkg::DIMREG_W-1:0] > DimCap) ?
		DimCap : pwdata[imm_pkg::DIMREG_W-1:0];

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			imm_pkg::REG_ROWS_A:    prdata = 32'(rows_a_q);
			imm_pkg::REG_INNER_DIM: prdata = 32'(inner_dim_q);
			imm_pkg::REG_COLS_B:    prdata = 32'(cols_b_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= DimReset;
			inner_dim_q <= DimReset;
			cols_b_q <= DimReset;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				imm_pkg::REG_ROWS_A:    rows_a_q <= cfg_val;
				imm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_val;
				imm_pkg::REG_COLS_B:    cols_b_q <= cfg_val;
				default:                ;
			endcase
		end
	end

	// Command decode
	assign busy = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign row_x = {1'b0, cmd.row};
	assign col_x = {1'b0, cmd.col};
	assign a_ok = (row_x < rows_a_q) && (col_x < inner_dim_q);
	assign b_ok = (row_x < inner_dim_q) && (col_x < cols_b_q);
	assign r_ok = (row_x < rows_a_q) && (col_x < cols_b_q);
	assign a_we = accept && (cmd.mode == imm_pkg::MODE_WR_A) && a_ok;
	assign b_we = accept && (cmd.mode == imm_pkg::MODE_WR_B) && b_ok;
	assign w_addr = AW'(int'(cmd.row) * DIM + int'(cmd.col));

	assign a_raddr = AW'(int'(row_q) * DIM + int'(k_q));
	assign b_raddr = AW'(int'(k_q) * DIM + int'(col_q));
	assign last_issue = (k_q == inner_dim_q - 4'd1);
	assign mul_full = a_rdata * b_rdata;

	imm_ram #(
		.WIDTH(imm_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (w_addr),
		.wdata (cmd.element),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	imm_ram #(
		.WIDTH(imm_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (w_addr),
		.wdata (cmd.element),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Sequencer, multiply-accumulate pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			prod_s2 <= '0;
			acc_q <= '0;
			done <= 1'b0;
			result <= '0;
		end else begin
			done <= 1'b0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			prod_s2 <= mul_full;
			if (v_s2) begin
				acc_q <= acc_q + prod_s2;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.mode)
							imm_pkg::MODE_WR_A: begin
								if (!a_ok) begin
									done <= 1'b1;
									result <= '{product: '0, index_error: 1'b1};
								end
							end
							imm_pkg::MODE_WR_B: begin
								if (!b_ok) begin
									done <= 1'b1;
									result <= '{product: '0, index_error: 1'b1};
								end
							end
							imm_pkg::MODE_READ: begin
								if (!r_ok) begin
									done <= 1'b1;
									result <= '{product: '0, index_error: 1'b1};
								end else if (inner_dim_q == '0) begin
									done <= 1'b1;
									result <= '{product: '0, index_error: 1'b0};
								end else begin
									row_q <= cmd.row;
									col_q <= cmd.col;
									k_q <= '0;
									acc_q <= '0;
									state_q <= ST_RUN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					v_s1 <= 1'b1;
					last_s1 <= last_issue;
					k_q <= k_q + 4'd1;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) begin
						done <= 1'b1;
						result <= '{product: acc_q + prod_s2, index_error: 1'b0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/imm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
